### rtl/core/rc4_pkg.sv
// shared types and constants for the rc4 stream cipher core
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

    // permutation and key store depth
    localparam int PERM_SIZE = 256;

    // longest key kept, in bytes (1 to 256)
    localparam int KEY_MAX = 256;
    localparam logic [8:0] KEY_LIMIT = 9'(KEY_MAX);

    // command queue between front and engine
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam logic [FIFO_AW:0] FIFO_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);

    // input operation codes carried on tuser
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef enum logic [1:0] {
        CMD_KEY,
        CMD_KEY_LAST,
        CMD_DATA
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } fifo_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_J,
        ST_KS_SW,
        ST_KS_FIN,
        ST_DA_J,
        ST_DA_T,
        ST_DA_FIN
    } eng_state_t;

endpackage

`default_nettype wire

### rtl/core/rc4_stream_cipher_core.sv
// top level of the rc4 stream cipher core
// keyed data passes ST_DA_J, ST_DA_T, ST_DA_FIN, three dependent permutation reads,
// into the output register; the next is taken in ST_DA_FIN once that register is free;
// unkeyed data goes straight to the output register; the last key byte starts a schedule
// (256 identity writes, then 256 swap steps through ST_KS_J, ST_KS_SW and ST_KS_FIN)
// reset: synchronous active low, clears indices, key length and keyed flag; no memory clear
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher_core
    import rc4_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] byte_value
    input  wire logic       s_tuser,   // [0] op: key byte or data byte
    input  wire logic       s_tlast,   // last_byte, final key byte
    // result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser    // [0] no_key
);

    // front to queue push, queue head to engine
    fifo_entry_t push;
    fifo_entry_t head;
    logic        fifo_full;
    logic        pop;

    // front end: decodes each beat into a key, last key or data command
    rc4_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .push      (push)
    );

    // command queue lets the front keep taking beats during engine work
    rc4_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (fifo_full),
        .head    (head),
        .pop     (pop)
    );

    // engine: key store, schedule sequencer and keystream pipeline
    // the output register decouples it from the master side
    rc4_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### rtl/core/rc4_front.sv
// input front end: classifies incoming beats into engine commands
`timescale 1ns / 1ps
`default_nettype none

module rc4_front
    import rc4_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_value
    input  wire logic        s_tuser,   // op
    input  wire logic        s_tlast,   // last_byte
    input  wire logic        fifo_full,
    output fifo_entry_t      push
);

    cmd_kind_t kind;

    always_comb begin
        case (s_tuser)
            OP_KEY:  kind = s_tlast ? CMD_KEY_LAST : CMD_KEY;
            OP_DATA: kind = CMD_DATA;
            default: kind = CMD_DATA;
        endcase
    end

    assign s_tready       = !fifo_full;
    assign push.valid     = s_tvalid && !fifo_full;
    assign push.cmd.kind  = kind;
    assign push.cmd.value = s_tdata;

endmodule

`default_nettype wire

### rtl/core/rc4_cmd_fifo.sv
// short command queue between the front end and the cipher engine
`timescale 1ns / 1ps
`default_nettype none

module rc4_cmd_fifo
    import rc4_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire fifo_entry_t push,
    output logic             full,
    output fifo_entry_t      head,
    input  wire logic        pop
);

    cmd_t               entry_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == FIFO_FULL);
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push.cmd;
        end
    end

`ifndef SYNTHESIS
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty command queue");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> count_reg != FIFO_FULL)
        else $error("push into full command queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_FULL)
        else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/rc4_engine.sv
// cipher engine: key store, permutation memory, key schedule and keystream
`timescale 1ns / 1ps
`default_nettype none

module rc4_engine
    import rc4_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire fifo_entry_t head,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser
);

    logic [7:0] perm_mem [PERM_SIZE];
    logic [7:0] key_mem  [PERM_SIZE];

    eng_state_t state_reg, state_next;

    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] n_reg, n_next;
    logic [7:0] kidx_reg, kidx_next;
    logic [8:0] klen_reg, klen_next;
    logic       keyed_reg, keyed_next;
    logic [7:0] sv_reg, sv_next;
    logic [7:0] t_reg, t_next;
    logic       tj_hit_reg, tj_hit_next;
    logic [7:0] byte_reg, byte_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_nokey_reg;

    logic       perm_we;
    logic [7:0] perm_wa, perm_wd, perm_ra;
    logic [7:0] perm_rdata_reg;
    logic       byp_hit_reg;
    logic [7:0] byp_data_reg;
    logic [7:0] perm_rd;
    logic       key_we;
    logic [7:0] key_rdata_reg;

    logic       out_free;
    logic       out_load;
    logic [7:0] out_data;
    logic       out_nokey;
    logic [7:0] i_inc;
    logic [8:0] len_eff;
    logic [7:0] kidx_adv;
    logic [7:0] jn;
    logic [7:0] tn;
    logic       head_data;

    assign out_free  = !m_valid_reg || m_tready;
    assign perm_rd   = byp_hit_reg ? byp_data_reg : perm_rdata_reg;
    assign i_inc     = i_reg + 8'd1;
    assign len_eff   = (klen_reg == 9'd0) ? 9'd1 : klen_reg;
    assign kidx_adv  = (({1'b0, kidx_reg} + 9'd1) == len_eff) ? 8'd0 : kidx_reg + 8'd1;
    assign head_data = head.valid && (head.cmd.kind == CMD_DATA);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    case (head.cmd.kind)
                        CMD_KEY_LAST: state_next = ST_INIT;
                        CMD_DATA:     state_next = keyed_reg ? ST_DA_J : ST_IDLE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                if (n_reg == 8'hFF) begin
                    state_next = ST_KS_J;
                end
            end
            ST_KS_J:   state_next = ST_KS_SW;
            ST_KS_SW:  state_next = ST_KS_FIN;
            ST_KS_FIN: state_next = (n_reg == 8'hFF) ? ST_IDLE : ST_KS_J;
            ST_DA_J:   state_next = ST_DA_T;
            ST_DA_T:   state_next = ST_DA_FIN;
            ST_DA_FIN: begin
                if (out_free) begin
                    state_next = head_data ? ST_DA_J : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath control and next values
    always_comb begin
        pop         = 1'b0;
        perm_we     = 1'b0;
        perm_wa     = n_reg;
        perm_wd     = n_reg;
        perm_ra     = t_reg;
        key_we      = 1'b0;
        out_load    = 1'b0;
        out_data    = head.cmd.value;
        out_nokey   = 1'b0;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        kidx_next   = kidx_reg;
        klen_next   = klen_reg;
        keyed_next  = keyed_reg;
        sv_next     = sv_reg;
        t_next      = t_reg;
        tj_hit_next = tj_hit_reg;
        byte_next   = byte_reg;
        jn          = j_reg + perm_rd;
        tn          = sv_reg + perm_rd;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    case (head.cmd.kind)
                        CMD_KEY, CMD_KEY_LAST: begin
                            pop    = 1'b1;
                            n_next = 8'd0;
                            if (klen_reg < KEY_LIMIT) begin
                                key_we    = 1'b1;
                                klen_next = klen_reg + 9'd1;
                            end
                        end
                        CMD_DATA: begin
                            if (keyed_reg) begin
                                pop       = 1'b1;
                                perm_ra   = i_inc;
                                i_next    = i_inc;
                                byte_next = head.cmd.value;
                            end else if (out_free) begin
                                // unkeyed data passes straight through
                                pop       = 1'b1;
                                out_load  = 1'b1;
                                out_data  = head.cmd.value;
                                out_nokey = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                // identity fill, one entry a cycle
                perm_we   = 1'b1;
                perm_wa   = n_reg;
                perm_wd   = n_reg;
                perm_ra   = 8'd0;
                n_next    = n_reg + 8'd1;
                j_next    = 8'd0;
                kidx_next = 8'd0;
            end
            ST_KS_J: begin
                jn      = j_reg + perm_rd + key_rdata_reg;
                j_next  = jn;
                sv_next = perm_rd;
                perm_ra = jn;
            end
            ST_KS_SW: begin
                perm_we = 1'b1;
                perm_wa = n_reg;
                perm_wd = perm_rd;
            end
            ST_KS_FIN: begin
                perm_we = 1'b1;
                perm_wa = j_reg;
                perm_wd = sv_reg;
                if (n_reg == 8'hFF) begin
                    n_next     = 8'd0;
                    i_next     = 8'd0;
                    j_next     = 8'd0;
                    keyed_next = 1'b1;
                    klen_next  = 9'd0;
                end else begin
                    n_next    = n_reg + 8'd1;
                    kidx_next = kidx_adv;
                    perm_ra   = n_reg + 8'd1;
                end
            end
            ST_DA_J: begin
                j_next  = jn;
                sv_next = perm_rd;
                perm_ra = jn;
            end
            ST_DA_T: begin
                perm_we     = 1'b1;
                perm_wa     = i_reg;
                perm_wd     = perm_rd;
                t_next      = tn;
                perm_ra     = tn;
                tj_hit_next = (tn == j_reg);
            end
            ST_DA_FIN: begin
                perm_ra = t_reg;
                if (out_free) begin
                    perm_we   = 1'b1;
                    perm_wa   = j_reg;
                    perm_wd   = sv_reg;
                    out_load  = 1'b1;
                    out_data  = byte_reg ^ (tj_hit_reg ? sv_reg : perm_rd);
                    out_nokey = 1'b0;
                    if (head_data) begin
                        pop       = 1'b1;
                        perm_ra   = i_inc;
                        i_next    = i_inc;
                        byte_next = head.cmd.value;
                    end
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= 8'd0;
            j_reg       <= 8'd0;
            n_reg       <= 8'd0;
            kidx_reg    <= 8'd0;
            klen_reg    <= 9'd0;
            keyed_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            kidx_reg    <= kidx_next;
            klen_reg    <= klen_next;
            keyed_reg   <= keyed_next;
            m_valid_reg <= m_valid_next;
            byp_hit_reg <= perm_we && (perm_wa == perm_ra);
        end
    end

    always_ff @(posedge aclk) begin
        sv_reg     <= sv_next;
        t_reg      <= t_next;
        tj_hit_reg <= tj_hit_next;
        byte_reg   <= byte_next;
        if (out_load) begin
            m_data_reg  <= out_data;
            m_nokey_reg <= out_nokey;
        end
    end

    // permutation memory, write-first bypass on the registered read
    always_ff @(posedge aclk) begin
        if (perm_we) begin
            perm_mem[perm_wa] <= perm_wd;
        end
        perm_rdata_reg <= perm_mem[perm_ra];
        byp_data_reg   <= perm_wd;
    end

    // key store, read at kidx_next so that key_rdata_reg matches kidx_reg
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[klen_reg[7:0]] <= head.cmd.value;
        end
        key_rdata_reg <= key_mem[kidx_next];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_nokey_reg;

`ifndef SYNTHESIS
    a_keyed_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> keyed_reg)
        else $error("keystream output before any key schedule");

    a_no_pop_in_schedule: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT || state_reg == ST_KS_J || state_reg == ST_KS_SW ||
         state_reg == ST_KS_FIN) |-> !pop)
        else $error("command taken during key schedule");

    a_klen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        klen_reg <= KEY_LIMIT)
        else $error("key length beyond limit");

    a_schedule_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_KS_FIN && n_reg == 8'hFF |=> keyed_reg && klen_reg == 9'd0)
        else $error("key schedule did not finish cleanly");
`endif

endmodule

`default_nettype wire

### test/tb_rc4_stream_cipher_core.sv
// testbench for the rc4 stream cipher core: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_core;
    import rc4_pkg::*;

    // cycles without any beat on either side before the run is abandoned;
    // a key schedule holds the input side once the command queue is full
    localparam int STALL_LIMIT = 8000;
    // quiet cycles after the last expected byte
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       no_key;
    } cipher_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] byte_value
    logic       s_tuser  = OP_KEY;  // [0] op
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tuser;            // [0] no_key

    // predictor state
    logic [7:0]   sbox [PERM_SIZE];
    logic [7:0]   key_bytes [PERM_SIZE];
    int unsigned  key_count;
    logic [7:0]   idx_i;
    logic [7:0]   idx_j;
    bit           have_key;

    cipher_byte_t pending_cipher_bytes [$];
    cipher_byte_t oldest_cipher_byte;
    int           error_count = 0;
    int           beats_counted = 0;
    int unsigned  tx_idle_pct = 27;
    int unsigned  rx_idle_pct = 62;

    rc4_stream_cipher_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // identity fill then 256 swap steps with the key repeated over its length
    task automatic schedule_permutation();
        int unsigned len;
        logic [7:0]  jj;
        logic [7:0]  tmp;
        len = (key_count == 0) ? 1 : key_count;
        for (int n = 0; n < PERM_SIZE; n++) sbox[n] = n[7:0];
        jj = 8'h00;
        for (int n = 0; n < PERM_SIZE; n++) begin
            jj = jj + sbox[n] + key_bytes[n % len];
            tmp = sbox[n];
            sbox[n] = sbox[jj];
            sbox[jj] = tmp;
        end
        idx_i = 8'h00;
        idx_j = 8'h00;
        have_key = 1'b1;
        key_count = 0;
    endtask

    task automatic cipher_predict(input logic op, input logic [7:0] val, input logic lst);
        logic [7:0]   tmp;
        cipher_byte_t res;
        if (op == OP_KEY) begin
            if (key_count < KEY_MAX) begin
                key_bytes[key_count] = val;
                key_count++;
            end
            if (lst) schedule_permutation();
        end else if (!have_key) begin
            res.out_byte = val;
            res.no_key = 1'b1;
            pending_cipher_bytes.push_back(res);
        end else begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + sbox[idx_i];
            tmp = sbox[idx_i];
            sbox[idx_i] = sbox[idx_j];
            sbox[idx_j] = tmp;
            res.out_byte = val ^ sbox[8'(sbox[idx_i] + sbox[idx_j])];
            res.no_key = 1'b0;
            pending_cipher_bytes.push_back(res);
        end
    endtask

    // one input beat, with a random hold-off; returns at the edge that accepts it
    task automatic send_beat(input logic op, input logic [7:0] val, input logic lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // key bytes past the key limit are dropped by the block
        if (!(op == OP_KEY && key_count >= KEY_MAX)) beats_counted++;
        cipher_predict(op, val, lst);
    endtask

    task automatic send_key(input logic [7:0] bytes [], input bit mark_last);
        foreach (bytes[n])
            send_beat(OP_KEY, bytes[n], mark_last && (n == bytes.size() - 1));
    endtask

    task automatic test_unkeyed_data();
        send_beat(OP_DATA, 8'h00, 1'b0);
        send_beat(OP_DATA, 8'hFF, 1'b1);
        send_beat(OP_DATA, 8'hA5, 1'b0);
        send_beat(OP_DATA, 8'h5A, 1'b1);
    endtask

    // classic "Key" / "Plaintext" pair, then single byte keys at both extremes
    task automatic test_known_keys();
        logic [7:0] key_word [] = '{8'h4B, 8'h65, 8'h79};
        logic [7:0] text [] = '{8'h50, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h78, 8'h74};
        send_key(key_word, 1'b1);
        foreach (text[n]) send_beat(OP_DATA, text[n], n[0]);
        send_beat(OP_KEY, 8'h00, 1'b1);
        send_beat(OP_DATA, 8'h00, 1'b0);
        send_beat(OP_DATA, 8'hFF, 1'b1);
        send_beat(OP_KEY, 8'hFF, 1'b1);
        send_beat(OP_DATA, 8'hFF, 1'b0);
        send_beat(OP_DATA, 8'h00, 1'b0);
    endtask

    // key runs past the key limit; the mark on a dropped byte still schedules
    task automatic test_key_saturation();
        for (int n = 0; n < KEY_MAX + 2; n++)
            send_beat(OP_KEY, 8'($urandom_range(255)), n == KEY_MAX + 1);
        for (int n = 0; n < 4; n++)
            send_beat(OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // one key followed by data; some keys are interrupted by data or left unmarked
    task automatic run_key_session();
        int  key_len;
        int  split_at;
        int  sel;
        bit  mark_last;
        sel = $urandom_range(99);
        if (sel < 14) key_len = $urandom_range(64, 17);
        else key_len = $urandom_range(16, 1);
        split_at = ($urandom_range(99) < 15) ? $urandom_range(key_len - 1, 0) : -1;
        mark_last = ($urandom_range(99) >= 5);
        for (int n = 0; n < key_len; n++) begin
            if (n == split_at) begin
                repeat ($urandom_range(4, 1))
                    send_beat(OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            send_beat(OP_KEY, 8'($urandom_range(255)), mark_last && (n == key_len - 1));
        end
        repeat ($urandom_range(40, 0))
            send_beat(OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int target);
        int start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = beats_counted;
        while (beats_counted - start < target) run_key_session();
    endtask

    // result side: compare each beat with the oldest prediction, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cipher_bytes.size() == 0) begin
                $error("unexpected result beat: out_byte %0h no_key %0b", m_tdata, m_tuser);
                error_count++;
            end else begin
                oldest_cipher_byte = pending_cipher_bytes.pop_front();
                if (m_tdata !== oldest_cipher_byte.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h",
                           oldest_cipher_byte.out_byte, m_tdata);
                    error_count++;
                end
                if (m_tuser !== oldest_cipher_byte.no_key) begin
                    $error("no_key: expected %0b, actual %0b",
                           oldest_cipher_byte.no_key, m_tuser);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        key_count = 0;
        idx_i = 8'h00;
        idx_j = 8'h00;
        have_key = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unkeyed_data();
        test_known_keys();
        test_key_saturation();
        test_random_traffic(27, 62, 30);
        test_random_traffic(62, 27, 30);
        test_random_traffic(0, 0, 30);

        s_tvalid <= 1'b0;
        while (pending_cipher_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_cipher_bytes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### rc4_stream_cipher_core.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_front.sv
rtl/core/rc4_cmd_fifo.sv
rtl/core/rc4_engine.sv
rtl/core/rc4_stream_cipher_core.sv
test/tb_rc4_stream_cipher_core.sv
